[sv/qte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and helpers for the quaternion to Euler block.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 14;
  localparam int TABLE_LEN     = 24;
  localparam int NIT = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int ZW  = FRACTION_BITS + 4;   // angle accumulator
  localparam int QW  = ZW + 4;              // angle during final scaling
  localparam int CW  = 37;                  // CORDIC x/y
  localparam int RW  = 64;                  // square root radicand
  localparam int SQ_STEPS = 32;

  localparam int QSH    = 30 - FRACTION_BITS;
  localparam int SH_DN  = (FRACTION_BITS > 13) ? FRACTION_BITS - 13 : 0;
  localparam int SH_UP  = (FRACTION_BITS < 13) ? 13 - FRACTION_BITS : 0;

  localparam int LIM_FULL = 25736;
  localparam int LIM_HALF = 12868;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic signed [CW-1:0] ONE_Q28 = CW'(64'sd268435456);

  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  typedef struct packed {
    logic signed [CW-1:0] psi_x;
    logic signed [CW-1:0] psi_y;
    logic signed [CW-1:0] phi_x;
    logic signed [CW-1:0] phi_y;
    logic signed [CW-1:0] s;
    logic signed [15:0]   gx;
    logic signed [15:0]   gy;
    logic signed [15:0]   gz;
  } pay_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } grav_t;

  typedef struct packed {
    logic [31:0] ct;
    logic [31:0] cp;
    logic [31:0] cr;
  } root_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cl_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] psi;
    logic signed [14:0] theta;
    logic signed [15:0] phi;
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
  } res_t;

  function automatic logic signed [ZW-1:0] q30_to_work(input logic [63:0] a);
    logic [63:0] t;
    if (QSH > 0) begin
      t = (a + (64'd1 << ((QSH > 0) ? QSH - 1 : 0))) >> QSH;
    end else begin
      t = a;
    end
    return $signed(t[ZW-1:0]);
  endfunction

  function automatic logic signed [15:0] work_to_q13(input logic signed [ZW-1:0] z,
                                                     input int lim);
    logic signed [QW-1:0] zz;
    logic signed [QW-1:0] r;
    zz = QW'(z);
    if (SH_DN > 0) begin
      r = (zz + (QW'(1) <<< ((SH_DN > 0) ? SH_DN - 1 : 0))) >>> SH_DN;
    end else begin
      r = zz <<< SH_UP;
    end
    if (r > QW'(lim)) begin
      r = QW'(lim);
    end else if (r < -QW'(lim)) begin
      r = -QW'(lim);
    end
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) begin
      return 16'sh7fff;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

[sv/quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
// Pipeline: 4 front stages, 32 square root stages (one root bit each),
//   1 quadrant stage, NIT rotation stages and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output.
// Reset: synchronous, clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion to gravity vector, Euler angles, pitch and roll.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // gravity_x, gravity_y, gravity_z,
                                  // heading_psi, tilt_theta, bank_phi,
                                  // pitch_angle, roll_angle, 3 zero bits
);
  import qte_pkg::*;

  logic           en;
  logic           f_valid;
  pay_t           f_pay;
  logic [RW-1:0]  f_rt, f_rp, f_rr;
  logic           q_valid;
  pay_t           q_pay;
  root_t          q_roots;
  res_t           res;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .qw        (s_tdata[15:0]),
    .qx        (s_tdata[31:16]),
    .qy        (s_tdata[47:32]),
    .qz        (s_tdata[63:48]),
    .out_valid (f_valid),
    .pay       (f_pay),
    .rad_t     (f_rt),
    .rad_p     (f_rp),
    .rad_r     (f_rr)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .pay_in    (f_pay),
    .rad_t     (f_rt),
    .rad_p     (f_rp),
    .rad_r     (f_rr),
    .out_valid (q_valid),
    .pay_out   (q_pay),
    .roots     (q_roots)
  );

  qte_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .pay       (q_pay),
    .roots     (q_roots),
    .out_valid (m_tvalid),
    .res       (res)
  );

  assign m_tdata = {3'b000, res.roll, res.pitch, res.phi, res.theta, res.psi,
                    res.gz, res.gy, res.gx};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_psi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[63:48]) <= 16'sd25736 &&
                 $signed(m_tdata[63:48]) >= -16'sd25736)
    else $error("heading out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[109:95]) <= 15'sd12868 &&
                 $signed(m_tdata[109:95]) >= -15'sd12868)
    else $error("pitch out of range");

endmodule

[sv/qte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_front
// Products, gravity, CORDIC arguments and square root radicands (4 stages).
// ----------------------------------------------------------------------------
module qte_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [15:0]       qw,
  input  logic signed [15:0]       qx,
  input  logic signed [15:0]       qy,
  input  logic signed [15:0]       qz,
  output logic                     out_valid,
  output qte_pkg::pay_t            pay,
  output logic [qte_pkg::RW-1:0]   rad_t,
  output logic [qte_pkg::RW-1:0]   rad_p,
  output logic [qte_pkg::RW-1:0]   rad_r
);
  import qte_pkg::*;

  logic [3:0] vld;

  // stage 1
  logic signed [31:0] p_xz, p_wy, p_wx, p_yz, p_ww, p_xx, p_yy, p_zz, p_xy, p_wz;
  // stage 2
  pay_t pay2, pay2_next;
  // stage 3
  pay_t pay3;
  logic signed [59:0] ss;
  logic signed [31:0] gxx, gyy, gzz;

  logic signed [33:0] sum_x, sum_y;
  logic signed [34:0] sum_z, d_psi, d_phi;
  logic signed [CW-1:0] st;
  logic signed [29:0] s30;

  always_comb begin
    sum_x = 34'(p_xz) - 34'(p_wy) + 34'sd4096;
    sum_y = 34'(p_wx) + 34'(p_yz) + 34'sd4096;
    sum_z = 35'(p_ww) - 35'(p_xx) - 35'(p_yy) + 35'(p_zz) + 35'sd8192;
    d_psi = 35'(p_xy) - 35'(p_wz);
    d_phi = 35'(p_yz) - 35'(p_wx);
    pay2_next.gx    = sat16(36'(sum_x >>> 13));
    pay2_next.gy    = sat16(36'(sum_y >>> 13));
    pay2_next.gz    = sat16(36'(sum_z >>> 14));
    pay2_next.psi_y = CW'(d_psi) <<< 1;
    pay2_next.phi_y = CW'(d_phi) <<< 1;
    pay2_next.psi_x = ((CW'(p_ww) + CW'(p_xx)) <<< 1) - ONE_Q28;
    pay2_next.phi_x = ((CW'(p_ww) + CW'(p_zz)) <<< 1) - ONE_Q28;
    st = (CW'(p_xz) + CW'(p_wy)) <<< 1;
    if (st > ONE_Q28) begin
      st = ONE_Q28;
    end else if (st < -ONE_Q28) begin
      st = -ONE_Q28;
    end
    pay2_next.s = st;
    s30 = pay2.s[29:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      pay2 <= pay2_next;
      ss   <= s30 * s30;
      gxx  <= pay2.gx * pay2.gx;
      gyy  <= pay2.gy * pay2.gy;
      gzz  <= pay2.gz * pay2.gz;
      pay3 <= pay2;
      pay   <= pay3;
      rad_t <= (RW'(1) << 56) - RW'($unsigned(ss));
      rad_p <= (RW'($unsigned(gyy)) + RW'($unsigned(gzz))) << 28;
      rad_r <= (RW'($unsigned(gxx)) + RW'($unsigned(gzz))) << 28;
    end
  end

  assign out_valid = vld[3];

endmodule

[sv/qte_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt
// Three floor square roots, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  qte_pkg::pay_t          pay_in,
  input  logic [qte_pkg::RW-1:0] rad_t,
  input  logic [qte_pkg::RW-1:0] rad_p,
  input  logic [qte_pkg::RW-1:0] rad_r,
  output logic                   out_valid,
  output qte_pkg::pay_t          pay_out,
  output qte_pkg::root_t         roots
);
  import qte_pkg::*;

  logic [SQ_STEPS-1:0] vld;
  pay_t                pay_r [SQ_STEPS];
  logic [RW-1:0]       sv [SQ_STEPS][3];
  logic [RW-1:0]       sr [SQ_STEPS][3];
  logic [RW-1:0]       iv [SQ_STEPS][3];
  logic [RW-1:0]       ir [SQ_STEPS][3];
  logic [RW-1:0]       nv [SQ_STEPS][3];
  logic [RW-1:0]       nr [SQ_STEPS][3];

  always_comb begin
    logic [RW-1:0] b;
    iv[0][0] = rad_t;
    iv[0][1] = rad_p;
    iv[0][2] = rad_r;
    for (int k = 0; k < 3; k++) begin
      ir[0][k] = '0;
    end
    for (int i = 1; i < SQ_STEPS; i++) begin
      for (int k = 0; k < 3; k++) begin
        iv[i][k] = sv[i-1][k];
        ir[i][k] = sr[i-1][k];
      end
    end
    for (int i = 0; i < SQ_STEPS; i++) begin
      b = RW'(1) << (RW - 2 - 2 * i);
      for (int k = 0; k < 3; k++) begin
        if (iv[i][k] >= ir[i][k] + b) begin
          nv[i][k] = iv[i][k] - (ir[i][k] + b);
          nr[i][k] = (ir[i][k] >> 1) + b;
        end else begin
          nv[i][k] = iv[i][k];
          nr[i][k] = ir[i][k] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQ_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= pay_in;
      for (int i = 1; i < SQ_STEPS; i++) begin
        pay_r[i] <= pay_r[i-1];
      end
      for (int i = 0; i < SQ_STEPS; i++) begin
        for (int k = 0; k < 3; k++) begin
          sv[i][k] <= nv[i][k];
          sr[i][k] <= nr[i][k];
        end
      end
    end
  end

  assign out_valid = vld[SQ_STEPS-1];
  assign pay_out   = pay_r[SQ_STEPS-1];
  assign roots.ct  = sr[SQ_STEPS-1][0][31:0];
  assign roots.cp  = sr[SQ_STEPS-1][1][31:0];
  assign roots.cr  = sr[SQ_STEPS-1][2][31:0];

endmodule

[sv/qte_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Five vectoring CORDIC lanes, one iteration per stage, then angle scaling
// into the output register.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  qte_pkg::pay_t  pay,
  input  qte_pkg::root_t roots,
  output logic           out_valid,
  output qte_pkg::res_t  res
);
  import qte_pkg::*;

  // lanes: psi, phi, theta, pitch, roll
  localparam int NL = 5;

  logic [NIT+1:0] vld;
  cl_t            cl  [NIT+1][NL];
  cl_t            nxt [NIT][NL];
  cl_t            pre [NL];
  grav_t          grv [NIT+1];
  grav_t          grv_in;
  logic signed [CW-1:0] ax [NL];
  logic signed [CW-1:0] ay [NL];
  logic signed [ZW-1:0] zf [NL];
  logic signed [15:0]   theta_pos;
  res_t                 res_next;

  function automatic cl_t prerot(input logic signed [CW-1:0] x,
                                 input logic signed [CW-1:0] y);
    cl_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.z = (y >= 0) ? q30_to_work(PI_Q30) : -q30_to_work(PI_Q30);
      c.x = -x;
      c.y = -y;
    end else begin
      c.z = '0;
      c.x = x;
      c.y = y;
    end
    return c;
  endfunction

  function automatic cl_t iter(input cl_t c, input int i);
    cl_t o;
    logic signed [ZW-1:0] a;
    a = q30_to_work(64'(ATAN_Q30[i]));
    o.zero = c.zero;
    if (c.y >= 0) begin
      o.x = c.x + (c.y >>> i);
      o.y = c.y - (c.x >>> i);
      o.z = c.z + a;
    end else begin
      o.x = c.x - (c.y >>> i);
      o.y = c.y + (c.x >>> i);
      o.z = c.z - a;
    end
    return o;
  endfunction

  always_comb begin
    ax[0] = pay.psi_x;  ay[0] = pay.psi_y;
    ax[1] = pay.phi_x;  ay[1] = pay.phi_y;
    ax[2] = CW'(roots.ct); ay[2] = pay.s;
    ax[3] = CW'(roots.cp); ay[3] = CW'(pay.gx) <<< 14;
    ax[4] = CW'(roots.cr); ay[4] = CW'(pay.gy) <<< 14;
    for (int k = 0; k < NL; k++) begin
      pre[k] = prerot(ax[k], ay[k]);
    end
    grv_in.gx = pay.gx;
    grv_in.gy = pay.gy;
    grv_in.gz = pay.gz;
    for (int j = 0; j < NIT; j++) begin
      for (int k = 0; k < NL; k++) begin
        nxt[j][k] = iter(cl[j][k], j);
      end
    end
    for (int k = 0; k < NL; k++) begin
      zf[k] = cl[NIT][k].zero ? '0 : cl[NIT][k].z;
    end
    theta_pos      = work_to_q13(zf[2], LIM_HALF);
    res_next.gx    = grv[NIT].gx;
    res_next.gy    = grv[NIT].gy;
    res_next.gz    = grv[NIT].gz;
    res_next.psi   = work_to_q13(zf[0], LIM_FULL);
    res_next.phi   = work_to_q13(zf[1], LIM_FULL);
    res_next.theta = 15'(-theta_pos);
    res_next.pitch = 15'(work_to_q13(zf[3], LIM_HALF));
    res_next.roll  = 15'(work_to_q13(zf[4], LIM_HALF));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NIT:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl[0]  <= pre;
      grv[0] <= grv_in;
      for (int j = 0; j < NIT; j++) begin
        cl[j+1]  <= nxt[j];
        grv[j+1] <= grv[j];
      end
      res <= res_next;
    end
  end

  assign out_valid = vld[NIT+1];

endmodule

[bench/tb_quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles
// Streams quaternions through the block and checks every result, field by
// field, against an in-bench fixed-point model of gravity and Euler angles,
// under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles;
  import qte_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;   // quat_w, quat_x, quat_y, quat_z
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // gx, gy, gz, psi, theta, phi, pitch, roll

  logic [63:0] quat_queue[$];
  res_t        angle_queue[$];
  int          n_sent = 0;
  int          n_errors = 0;
  int          snd_idle = 38;
  int          rcv_idle = 53;
  bit          hold_off = 1'b0;

  quaternion_to_euler_angles u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_tab(longint a);
    if (QSH <= 0) return a;
    return (a + (64'sd1 <<< (QSH - 1))) >>> QSH;
  endfunction

  function automatic longint to_q13(longint z, longint lim);
    longint r;
    int sh;
    sh = FRACTION_BITS - 13;
    if (sh > 0) r = (z + (64'sd1 <<< (sh - 1))) >>> sh;
    else r = z <<< (-sh);
    return clip(r, -lim, lim);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? round_tab(longint'(PI_Q30)) : -round_tab(longint'(PI_Q30));
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NIT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + round_tab(longint'(ATAN_Q30[i]));
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - round_tab(longint'(ATAN_Q30[i]));
      end
    end
    return ang;
  endfunction

  function automatic res_t euler_of(logic [63:0] d);
    longint w, x, y, z, gx, gy, gz, s, c, den;
    longint one;
    res_t r;
    one = 64'sd268435456;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    gx = clip((x * z - w * y + 4096) >>> 13, -32768, 32767);
    gy = clip((w * x + y * z + 4096) >>> 13, -32768, 32767);
    gz = clip((w * w - x * x - y * y + z * z + 8192) >>> 14, -32768, 32767);
    r.gx = gx[15:0];
    r.gy = gy[15:0];
    r.gz = gz[15:0];
    r.psi = 16'(to_q13(vector_angle(2 * (x * y - w * z), 2 * (w * w + x * x) - one),
                       LIM_FULL));
    r.phi = 16'(to_q13(vector_angle(2 * (y * z - w * x), 2 * (w * w + z * z) - one),
                       LIM_FULL));
    s = clip(2 * (x * z + w * y), -one, one);
    c = root_floor(longint'(one * one - s * s));
    r.theta = 15'(-to_q13(vector_angle(s, c), LIM_HALF));
    den = root_floor(longint'(gy * gy + gz * gz) << 28);
    r.pitch = 15'(to_q13(vector_angle(gx * 16384, den), LIM_HALF));
    den = root_floor(longint'(gx * gx + gz * gz) << 28);
    r.roll = 15'(to_q13(vector_angle(gy * 16384, den), LIM_HALF));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    n_errors++;
  endtask

  function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        angle_queue.push_back(euler_of(s_tdata));
        n_sent++;
        nv = 1'b0;
      end
      if (!nv && quat_queue.size() > 0 && $urandom_range(99) >= snd_idle) begin
        s_tdata <= quat_queue.pop_front();
        nv = 1'b1;
      end
      s_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.gx = m_tdata[15:0];
        got.gy = m_tdata[31:16];
        got.gz = m_tdata[47:32];
        got.psi = m_tdata[63:48];
        got.theta = m_tdata[78:64];
        got.phi = m_tdata[94:79];
        got.pitch = m_tdata[109:95];
        got.roll = m_tdata[124:110];
        if (angle_queue.size() == 0) begin
          $display("result with nothing expected");
          n_errors++;
        end else begin
          want = angle_queue.pop_front();
          if (got.gx != want.gx) report_mismatch("gravity_x", got.gx, want.gx);
          if (got.gy != want.gy) report_mismatch("gravity_y", got.gy, want.gy);
          if (got.gz != want.gz) report_mismatch("gravity_z", got.gz, want.gz);
          if (got.psi != want.psi) report_mismatch("heading_psi", got.psi, want.psi);
          if (got.theta != want.theta)
            report_mismatch("tilt_theta", got.theta, want.theta);
          if (got.phi != want.phi) report_mismatch("bank_phi", got.phi, want.phi);
          if (got.pitch != want.pitch)
            report_mismatch("pitch_angle", got.pitch, want.pitch);
          if (got.roll != want.roll) report_mismatch("roll_angle", got.roll, want.roll);
          if (m_tdata[127:125] != 3'b000) report_mismatch("pad bits", m_tdata[127:125], 0);
        end
      end
      m_tready <= !hold_off && ($urandom_range(99) >= rcv_idle);
    end
  end

  // long output stall; the whole pipeline holds while it lasts
  initial begin
    wait (n_sent >= 300);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("** quaternion_to_euler_angles: FAILED **");
    $finish;
  end

  initial begin
    real a, b, c, d, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    quat_queue.push_back(pack_quat(0, 0, 0, 0));
    quat_queue.push_back(pack_quat(16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 16384, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 16384, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 16384));
    quat_queue.push_back(pack_quat(0, 0, 0, -16384));
    quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
    quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
    quat_queue.push_back(pack_quat(11585, 11585, 0, 0));
    quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
    quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(pack_quat(32767, 0, 32767, 0));
    quat_queue.push_back(pack_quat(-32768, 0, 32767, 0));
    quat_queue.push_back(pack_quat(0, 32767, 0, 32767));
    quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
    quat_queue.push_back(pack_quat(1, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 1));
    for (int i = 0; i < 1650; i++) begin
      if ($urandom_range(3) == 0) begin
        quat_queue.push_back({$urandom, $urandom});
      end else begin
        // near-unit quaternion with random direction
        a = real'($signed(16'($urandom)));
        b = real'($signed(16'($urandom)));
        c = real'($signed(16'($urandom)));
        d = real'($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        n = (16384.0 + real'($urandom_range(64)) - 32.0) / n;
        quat_queue.push_back(pack_quat(int'(a * n), int'(b * n), int'(c * n),
                                       int'(d * n)));
      end
    end
    wait (n_sent >= 600);
    snd_idle = 53;
    rcv_idle = 38;
    wait (n_sent >= 1200);
    snd_idle = 0;
    rcv_idle = 0;
    wait (quat_queue.size() == 0 && !s_tvalid && angle_queue.size() == 0);
    repeat (80) @(posedge clk);
    if (n_errors == 0) begin
      $display("** quaternion_to_euler_angles: PASSED **");
    end else begin
      $display("** quaternion_to_euler_angles: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/qte_pkg.sv
sv/qte_front.sv
sv/qte_sqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles.sv
bench/tb_quaternion_to_euler_angles.sv
